/* rtl/core/btlv_pkg.sv */
// Shared constants and result codes for the BER TLV stream parser.
package btlv_pkg;

	localparam int unsigned MAX_LEN_BYTES = 4;

	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_VALUE  = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	localparam logic [7:0] LONG_FORM_BIT = 8'h80;
	localparam logic [7:0] COUNT_MASK    = 8'h7F;

endpackage

/* rtl/core/ber_tlv_stream_parser_top.sv */
// Top level of the BER TLV stream parser: input register, record state and result register.
//
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_stall    in_byte
// output    out        out_valid / out_stall  kind, rec_tag, rec_length, value_byte, last
//
// An accepted byte is held in the input register and is parsed from there; the parse result is
// registered in the result register, and an output stall can hold the byte before it is parsed.
// One byte can be accepted in every cycle while the output is not stalled; the record state and
// the result register are updated by the same short logic from the input register, which sets the rate.
// Reset returns the parser to expecting a tag byte and empties both registers.
// A stall on the output holds the result and then the input register; the input stalls
// only while its register is full and cannot move on.
module ber_tlv_stream_parser_top
	import btlv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  rec_tag,
	output logic [31:0] rec_length,
	output logic [7:0]  value_byte,
	output logic        last
);

	localparam logic [1:0] PH_TAG    = 2'd0;
	localparam logic [1:0] PH_LEN    = 2'd1;
	localparam logic [1:0] PH_LBYTES = 2'd2;
	localparam logic [1:0] PH_VALUE  = 2'd3;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        advance;

	logic [1:0]  phase_q, phase_d;
	logic [7:0]  held_tag_q, held_tag_d;
	logic [31:0] length_accum_q, length_accum_d;
	logic [2:0]  length_bytes_left_q, length_bytes_left_d;
	logic [31:0] value_bytes_left_q, value_bytes_left_d;

	logic        res_valid;
	logic [1:0]  res_kind;
	logic [31:0] res_length;
	logic [7:0]  res_value;
	logic        res_last;
	logic [6:0]  count;
	logic [31:0] value_left_dec;

	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [7:0]  rec_tag_q;
	logic [31:0] rec_length_q;
	logic [7:0]  value_byte_q;
	logic        last_q;

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= in_byte;
		end
	end

	assign count          = byte_s1[6:0] & COUNT_MASK[6:0];
	assign value_left_dec = value_bytes_left_q - 32'd1;

	always_comb begin
		phase_d             = phase_q;
		held_tag_d          = held_tag_q;
		length_accum_d      = length_accum_q;
		length_bytes_left_d = length_bytes_left_q;
		value_bytes_left_d  = value_bytes_left_q;
		res_valid           = 1'b0;
		res_kind            = KIND_HEADER;
		res_length          = 32'd0;
		res_value           = 8'd0;
		res_last            = 1'b0;
		case (phase_q)
			PH_TAG: begin
				held_tag_d     = byte_s1;
				length_accum_d = 32'd0;
				phase_d        = PH_LEN;
			end
			PH_LEN: begin
				if ((byte_s1 & LONG_FORM_BIT) == 8'd0) begin
					length_accum_d     = {24'd0, byte_s1};
					value_bytes_left_d = {24'd0, byte_s1};
					res_valid          = 1'b1;
					res_length         = {24'd0, byte_s1};
					res_last           = (byte_s1 == 8'd0);
					phase_d            = (byte_s1 == 8'd0) ? PH_TAG : PH_VALUE;
				end else if (count == 7'd0) begin
					length_accum_d     = 32'd0;
					value_bytes_left_d = 32'd0;
					res_valid          = 1'b1;
					res_last           = 1'b1;
					phase_d            = PH_TAG;
				end else if (count > 7'(MAX_LEN_BYTES)) begin
					length_accum_d     = 32'd0;
					value_bytes_left_d = 32'd0;
					res_valid          = 1'b1;
					res_kind           = KIND_ERROR;
					res_last           = 1'b1;
					phase_d            = PH_TAG;
				end else begin
					length_accum_d      = 32'd0;
					length_bytes_left_d = count[2:0] - 3'd1;
					phase_d             = PH_LBYTES;
				end
			end
			PH_LBYTES: begin
				length_accum_d = {length_accum_q[23:0], byte_s1};
				if (length_bytes_left_q == 3'd0) begin
					value_bytes_left_d = {length_accum_q[23:0], byte_s1};
					res_valid          = 1'b1;
					res_length         = {length_accum_q[23:0], byte_s1};
					res_last           = ({length_accum_q[23:0], byte_s1} == 32'd0);
					phase_d            = res_last ? PH_TAG : PH_VALUE;
				end else begin
					length_bytes_left_d = length_bytes_left_q - 3'd1;
				end
			end
			PH_VALUE: begin
				if (value_bytes_left_q == 32'd0) begin
					held_tag_d     = byte_s1;
					length_accum_d = 32'd0;
					phase_d        = PH_LEN;
				end else begin
					value_bytes_left_d = value_left_dec;
					res_valid          = 1'b1;
					res_kind           = KIND_VALUE;
					res_length         = length_accum_q;
					res_value          = byte_s1;
					res_last           = (value_left_dec == 32'd0);
					if (value_left_dec == 32'd0) begin
						phase_d = PH_TAG;
					end
				end
			end
			default: begin
				phase_d = PH_TAG;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q             <= PH_TAG;
			held_tag_q          <= 8'd0;
			length_accum_q      <= 32'd0;
			length_bytes_left_q <= 3'd0;
			value_bytes_left_q  <= 32'd0;
			out_valid_q         <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && res_valid;
			if (valid_s1) begin
				phase_q             <= phase_d;
				held_tag_q          <= held_tag_d;
				length_accum_q      <= length_accum_d;
				length_bytes_left_q <= length_bytes_left_d;
				value_bytes_left_q  <= value_bytes_left_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && res_valid) begin
			kind_q       <= res_kind;
			rec_tag_q    <= held_tag_d;
			rec_length_q <= res_length;
			value_byte_q <= res_value;
			last_q       <= res_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign rec_tag    = rec_tag_q;
	assign rec_length = rec_length_q;
	assign value_byte = value_byte_q;
	assign last       = last_q;

	// An error result always closes its record.
	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_ERROR |-> last)
		else $error("error result without last");

	// A header for an empty record closes it.
	a_empty_header_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_HEADER && rec_length == 32'd0 |-> last)
		else $error("empty record header without last");

	// The input stalls only while the input register holds a byte.
	a_stall_needs_byte: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty input register");

	// A result that is not taken stays in place.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(rec_length) && $stable(kind))
		else $error("stalled result changed");

endmodule
